### hw/rtl/ats_pkg.sv
// shared types and constants for the alias table sampler
package ats_pkg;
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_OCC    = 2'd1,
    OP_BUILD  = 2'd2,
    OP_SAMPLE = 2'd3
  } op_t;
  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_PICK  = 2'd1,
    KIND_RETRY = 2'd2
  } kind_t;
endpackage

### hw/rtl/alias_table_sampler.sv
// alias table sampler: weight/flag loads, alias table build, sampling
//
//  channel | ports                                   | handshake
//  request | in_op in_entry_index in_weight          | start, busy
//          | in_occupied in_random_fraction          |
//  result  | out_kind out_sample_index               | out_strobe, one cycle
//  config  | cfg_we cfg_wdata                        | write on cfg_we
//
// load and flag ops write their table from idle and never raise busy. a sample
// keeps busy high through its steps: fraction scale multiply, table read, occupancy read, result.
// a build walks the entries once to scale and sort, then pairs entries, then
// flushes the stacks. all tables are one-port synchronous memories. synchronous
// reset clears control state; the flags and the cutoff and alias tables then
// take a clearing pass over MAX_ENTRIES entries after reset with busy high.
// the receiver cannot stall; each result shows for exactly one cycle.
module alias_table_sampler import ats_pkg::*; #(
  parameter int MAX_ENTRIES   = 64,
  parameter int FRACTION_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_op,
  input  logic [5:0]               in_entry_index,
  input  logic [FRACTION_BITS:0]   in_weight,
  input  logic                     in_occupied,
  input  logic [FRACTION_BITS-1:0] in_random_fraction,
  input  logic                     cfg_we,
  input  logic [6:0]               cfg_wdata,
  output logic                     out_strobe,
  output logic [1:0]               out_kind,
  output logic [5:0]               out_sample_index
);
  localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW  = AW + 1;
  localparam int SWW = FRACTION_BITS + 7;
  localparam int FB  = FRACTION_BITS;
  localparam logic [SWW-1:0] SW_MAX = {SWW{1'b1}};
  localparam logic [SWW-1:0] ONE_SW = SWW'(1) << FB;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_SC_RD, S_SC_MUL, S_SC_WR,
    S_PR_POP, S_PR_RDS, S_PR_RDL, S_PR_WR,
    S_FL_S, S_FL_L,
    S_SM_MUL, S_SM_RD, S_SM_OCC, S_SM_OUT
  } state_t;

  state_t state_r;
  logic [6:0]     cfg_r;
  logic [CW-1:0]  n_r;
  logic [CW-1:0]  j_r;
  logic [CW-1:0]  sc_r, lc_r;
  logic [AW-1:0]  sm_r, lg_r;
  logic [SWW-1:0] w_r, wsm_r;
  logic [FB+CW-1:0] u_r;
  logic [AW-1:0]  pick_r;
  logic [AW-1:0]  pick_nxt;
  logic           strobe_r;
  logic [1:0]     kind_r;
  logic [5:0]     idx_r;

  // memories
  logic [SWW-1:0] sw_mem [MAX_ENTRIES];
  logic [FB:0]    cut_mem [MAX_ENTRIES];
  logic [AW-1:0]  al_mem [MAX_ENTRIES];
  logic           occ_mem [MAX_ENTRIES];
  logic [AW-1:0]  ss_mem [MAX_ENTRIES];
  logic [AW-1:0]  ls_mem [MAX_ENTRIES];
  logic [SWW-1:0] sw_q;
  logic [FB:0]    cut_q;
  logic [AW-1:0]  al_q, ss_q, ls_q;
  logic           occ_q;

  // memory port controls
  logic sw_we, cut_we, al_we, occ_we, ss_we, ls_we;
  logic [AW-1:0] sw_a, cut_a, al_a, occ_a, ss_a, ls_a;
  logic [SWW-1:0] sw_d;
  logic [FB:0] cut_d;
  logic [AW-1:0] al_d, ss_d, ls_d;
  logic occ_d;

  always_ff @(posedge clk) begin
    if (sw_we) sw_mem[sw_a] <= sw_d;
    sw_q <= sw_mem[sw_a];
    if (cut_we) cut_mem[cut_a] <= cut_d;
    cut_q <= cut_mem[cut_a];
    if (al_we) al_mem[al_a] <= al_d;
    al_q <= al_mem[al_a];
    if (occ_we) occ_mem[occ_a] <= occ_d;
    occ_q <= occ_mem[occ_a];
    if (ss_we) ss_mem[ss_a] <= ss_d;
    ss_q <= ss_mem[ss_a];
    if (ls_we) ls_mem[ls_a] <= ls_d;
    ls_q <= ls_mem[ls_a];
  end

  // active count: 0 -> 1, saturate at MAX_ENTRIES
  logic [CW-1:0] n_act;
  always_comb begin
    if (cfg_r == 7'd0) n_act = CW'(1);
    else if (32'(cfg_r) > 32'(MAX_ENTRIES)) n_act = CW'(MAX_ENTRIES);
    else n_act = CW'(cfg_r);
  end

  logic in_range;
  assign in_range = 32'(in_entry_index) < 32'(MAX_ENTRIES);
  logic accept;
  assign accept = start && !busy;

  // scale: w*n with saturation
  logic [SWW+CW-1:0] prod;
  assign prod = w_r * n_r;
  logic [SWW-1:0] w_sat;
  assign w_sat = (prod > (SWW+CW)'(SW_MAX)) ? SW_MAX : prod[SWW-1:0];

  logic [SWW-1:0] lg_new;
  assign lg_new = sw_q - (ONE_SW - wsm_r);

  logic [AW-1:0] bin;
  always_comb begin
    if (32'(u_r[FB+CW-1:FB]) >= 32'(MAX_ENTRIES)) bin = AW'(MAX_ENTRIES - 1);
    else bin = u_r[FB+AW-1:FB];
  end

  // bin or its alias, from the table read of the previous cycle
  assign pick_nxt = ({1'b0, u_r[FB-1:0]} <= cut_q) ? bin : al_q;

  always_comb begin
    sw_we = 1'b0; sw_a = j_r[AW-1:0]; sw_d = w_sat;
    cut_we = 1'b0; cut_a = bin; cut_d = '0;
    al_we = 1'b0; al_a = bin; al_d = lg_r;
    occ_we = 1'b0; occ_a = pick_r; occ_d = 1'b0;
    ss_we = 1'b0; ss_a = sc_r[AW-1:0]; ss_d = j_r[AW-1:0];
    ls_we = 1'b0; ls_a = lc_r[AW-1:0]; ls_d = j_r[AW-1:0];
    case (state_r)
      S_CLR: begin
        cut_we = 1'b1; cut_a = j_r[AW-1:0];
        al_we = 1'b1; al_a = j_r[AW-1:0]; al_d = '0;
        occ_we = 1'b1; occ_a = j_r[AW-1:0];
      end
      S_IDLE: begin
        if (accept && in_range && in_op == OP_LOAD) begin
          sw_we = 1'b1; sw_a = AW'(in_entry_index);
          sw_d = SWW'(in_weight);
        end
        if (accept && in_range && in_op == OP_OCC) begin
          occ_we = 1'b1; occ_a = AW'(in_entry_index); occ_d = in_occupied;
        end
      end
      S_SC_WR: begin
        sw_we = 1'b1;
        if (w_sat > ONE_SW) ls_we = 1'b1;
        else ss_we = 1'b1;
      end
      S_PR_POP: begin
        ss_a = AW'(sc_r - CW'(1));
        ls_a = AW'(lc_r - CW'(1));
      end
      S_PR_RDS: sw_a = ss_q;
      S_PR_RDL: sw_a = lg_r;
      S_PR_WR: begin
        sw_we = 1'b1; sw_a = lg_r; sw_d = lg_new;
        cut_we = 1'b1; cut_a = sm_r; cut_d = wsm_r[FB:0];
        al_we = 1'b1; al_a = sm_r;
        if (lg_new > ONE_SW) begin
          ls_we = 1'b1; ls_d = lg_r;
        end else begin
          ss_we = 1'b1; ss_d = lg_r;
        end
      end
      S_FL_S: ss_a = AW'(sc_r - CW'(1));
      S_FL_L: ls_a = AW'(lc_r - CW'(1));
      S_SM_OCC: occ_a = pick_nxt;
      default: ;
    endcase
    // flush writes use stack output of previous cycle
    if ((state_r == S_FL_S || state_r == S_FL_L) && j_r[0]) begin
      cut_we = 1'b1; cut_a = (state_r == S_FL_S) ? ss_q : ls_q;
      cut_d = (FB+1)'(1) << FB;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cfg_r <= 7'd64;
      j_r <= '0;
      sc_r <= '0;
      lc_r <= '0;
      strobe_r <= 1'b0;
      kind_r <= KIND_DONE;
      idx_r <= '0;
    end else begin
      if (cfg_we) cfg_r <= cfg_wdata;
      strobe_r <= (state_r == S_SM_OUT) ||
                  (state_r == S_FL_L && !j_r[0] && lc_r == '0);
      case (state_r)
        S_CLR: begin
          if (j_r == CW'(MAX_ENTRIES - 1)) begin
            j_r <= '0; state_r <= S_IDLE;
          end else j_r <= j_r + CW'(1);
        end
        S_IDLE: begin
          if (accept && in_op == OP_BUILD) begin
            n_r <= n_act; j_r <= '0; sc_r <= '0; lc_r <= '0;
            state_r <= S_SC_RD;
          end else if (accept && in_op == OP_SAMPLE) begin
            n_r <= n_act; w_r <= SWW'(in_random_fraction);
            state_r <= S_SM_MUL;
          end
        end
        S_SC_RD: state_r <= S_SC_MUL;
        S_SC_MUL: begin
          w_r <= sw_q; state_r <= S_SC_WR;
        end
        S_SC_WR: begin
          if (w_sat > ONE_SW) lc_r <= lc_r + CW'(1);
          else sc_r <= sc_r + CW'(1);
          if (j_r == n_r - CW'(1)) state_r <= S_PR_POP;
          else begin
            j_r <= j_r + CW'(1); state_r <= S_SC_RD;
          end
        end
        S_PR_POP: begin
          if (sc_r != '0 && lc_r != '0) begin
            sc_r <= sc_r - CW'(1); lc_r <= lc_r - CW'(1);
            state_r <= S_PR_RDS;
          end else begin
            j_r <= '0; state_r <= S_FL_S;
          end
        end
        S_PR_RDS: begin
          sm_r <= ss_q; lg_r <= ls_q; state_r <= S_PR_RDL;
        end
        S_PR_RDL: begin
          wsm_r <= sw_q; state_r <= S_PR_WR;
        end
        S_PR_WR: begin
          if (lg_new > ONE_SW) lc_r <= lc_r + CW'(1);
          else sc_r <= sc_r + CW'(1);
          state_r <= S_PR_POP;
        end
        // j_r[0]: 0 = read stack top, 1 = write cutoff
        S_FL_S: begin
          if (j_r[0]) begin
            j_r <= '0; sc_r <= sc_r - CW'(1);
          end else if (sc_r == '0) state_r <= S_FL_L;
          else j_r <= CW'(1);
        end
        S_FL_L: begin
          if (j_r[0]) begin
            j_r <= '0; lc_r <= lc_r - CW'(1);
          end else if (lc_r == '0) begin
            kind_r <= KIND_DONE; idx_r <= '0;
            state_r <= S_IDLE;
          end else j_r <= CW'(1);
        end
        S_SM_MUL: begin
          u_r <= prod[FB+CW-1:0]; state_r <= S_SM_RD;
        end
        S_SM_RD: state_r <= S_SM_OCC;
        S_SM_OCC: begin
          pick_r <= pick_nxt;
          state_r <= S_SM_OUT;
        end
        S_SM_OUT: begin
          state_r <= S_IDLE;
          if (occ_q) begin
            kind_r <= KIND_PICK; idx_r <= 6'(pick_r);
          end else begin
            kind_r <= KIND_RETRY; idx_r <= '0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_kind = kind_r;
  assign out_sample_index = idx_r;

  a_busy_clr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> busy) else $error("busy low during clear");
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("strobe held");
  a_stack_sum: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PR_POP |-> 32'(sc_r) + 32'(lc_r) <= 32'(n_r))
    else $error("stack overflow");
endmodule
